// File: src/mcbf_pkg.sv
package mcbf_pkg;

    localparam int NUM_CHANNELS  = 8;
    localparam int CHANNEL_DEPTH = 256;
    localparam int MAX_READ      = 64;

    localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PTR_W     = $clog2(CHANNEL_DEPTH);
    localparam int CNT_W     = $clog2(CHANNEL_DEPTH + 1);
    localparam int RC_W      = (MAX_READ > 1) ? $clog2(MAX_READ + 1) : 1;
    localparam int CMP_W     = (CNT_W > 7) ? CNT_W : 7;
    localparam int ADDR_W    = CH_IDX_W + PTR_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NOFREE = 3'd1,
        ST_BADCH  = 3'd2,
        ST_FULL   = 3'd3,
        ST_EMPTY  = 3'd4
    } status_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load_req;
        logic commit;
        logic rd_start;
        logic rd_issue;
        logic rd_emit;
    } dp_cmd_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic read_go;
        logic slot_free;
        logic rd_more;
    } dp_stat_t;

    function automatic logic [CH_IDX_W-1:0] ch_index(input logic [2:0] c);
        return CH_IDX_W'(c);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(CHANNEL_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

// File: src/mcbf_ram.sv
module mcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/mcbf_datapath.sv
module mcbf_datapath
    import mcbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] opcode,
    input  logic [2:0] channel,
    input  logic [7:0] write_byte,
    input  logic [6:0] read_count,
    input  logic       out_ready,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    output logic       out_valid,
    output logic [2:0] status,
    output logic [7:0] read_byte,
    output logic [2:0] channel_out,
    output logic       last
);

    // Latched request.
    op_t        req_op_reg;
    logic [2:0] req_ch_reg;
    logic [7:0] req_byte_reg;
    logic [6:0] req_count_reg;

    // Channel table.
    logic [NUM_CHANNELS-1:0] free_reg;
    logic [PTR_W-1:0]        rp_reg  [NUM_CHANNELS];
    logic [PTR_W-1:0]        wp_reg  [NUM_CHANNELS];
    logic [CNT_W-1:0]        cnt_reg [NUM_CHANNELS];

    logic [RC_W-1:0] rem_reg;

    logic       out_valid_reg;
    status_t    out_status_reg;
    logic [7:0] out_byte_reg;
    logic [2:0] out_ch_reg;
    logic       out_last_reg;

    logic [CH_IDX_W-1:0] ch_idx;
    logic                ch_ok;
    logic [PTR_W-1:0]    cur_rp;
    logic [PTR_W-1:0]    cur_wp;
    logic [CNT_W-1:0]    cur_cnt;
    logic                full;
    logic                empty;
    logic                any_free;
    logic [CH_IDX_W-1:0] pick;
    status_t             single_status;
    logic [2:0]          single_ch;
    logic [RC_W-1:0]     n_bytes;
    logic [CMP_W-1:0]    n_work;
    logic                ram_we;
    logic [7:0]          ram_rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_op_reg    <= op_t'(opcode);
            req_ch_reg    <= channel;
            req_byte_reg  <= write_byte;
            req_count_reg <= read_count;
        end
    end

    assign ch_idx   = ch_index(req_ch_reg);
    assign ch_ok    = (int'(req_ch_reg) < NUM_CHANNELS) && !free_reg[ch_idx];
    assign cur_rp   = rp_reg[ch_idx];
    assign cur_wp   = wp_reg[ch_idx];
    assign cur_cnt  = cnt_reg[ch_idx];
    assign full     = (cur_cnt == CNT_W'(CHANNEL_DEPTH));
    assign empty    = (cur_cnt == '0);
    assign any_free = |free_reg;

    always_comb
    begin
        pick = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                pick = CH_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        single_status = ST_OK;
        single_ch     = req_ch_reg;
        case (req_op_reg)
            OP_ALLOC:
            begin
                if (any_free)
                begin
                    single_ch = 3'(pick);
                end
                else
                begin
                    single_status = ST_NOFREE;
                    single_ch     = 3'd0;
                end
            end
            OP_FREE:
            begin
                if (!ch_ok)
                begin
                    single_status = ST_BADCH;
                end
            end
            OP_WRITE:
            begin
                if (!ch_ok)
                begin
                    single_status = ST_BADCH;
                end
                else if (full)
                begin
                    single_status = ST_FULL;
                end
            end
            OP_READ:
            begin
                if (!ch_ok)
                begin
                    single_status = ST_BADCH;
                end
                else if (empty)
                begin
                    single_status = ST_EMPTY;
                end
            end
            default:
            begin
                single_status = ST_BADCH;
            end
        endcase
    end

    // Byte count of a read: a zero request counts as one, then it is capped
    // by the per-request limit and by what the channel holds.
    always_comb
    begin
        n_work = (req_count_reg == 7'd0) ? CMP_W'(1) : CMP_W'(req_count_reg);
        if (n_work > CMP_W'(MAX_READ))
        begin
            n_work = CMP_W'(MAX_READ);
        end
        if (n_work > CMP_W'(cur_cnt))
        begin
            n_work = CMP_W'(cur_cnt);
        end
        n_bytes = RC_W'(n_work);
    end

    assign stat.read_go   = (req_op_reg == OP_READ) && ch_ok && !empty;
    assign stat.slot_free = !out_valid_reg || out_ready;
    assign stat.rd_more   = (rem_reg != '0);

    assign ram_we = cmd.commit && (req_op_reg == OP_WRITE) && ch_ok && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
            rem_reg  <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                rp_reg[i]  <= '0;
                wp_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.commit)
            begin
                case (req_op_reg)
                    OP_ALLOC:
                    begin
                        if (any_free)
                        begin
                            free_reg[pick] <= 1'b0;
                            rp_reg[pick]   <= '0;
                            wp_reg[pick]   <= '0;
                            cnt_reg[pick]  <= '0;
                        end
                    end
                    OP_FREE:
                    begin
                        if (ch_ok)
                        begin
                            free_reg[ch_idx] <= 1'b1;
                            rp_reg[ch_idx]   <= '0;
                            wp_reg[ch_idx]   <= '0;
                            cnt_reg[ch_idx]  <= '0;
                        end
                    end
                    OP_WRITE:
                    begin
                        if (ram_we)
                        begin
                            wp_reg[ch_idx]  <= ptr_inc(cur_wp);
                            cnt_reg[ch_idx] <= cur_cnt + CNT_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.rd_start)
            begin
                rem_reg <= n_bytes;
            end
            if (cmd.rd_issue)
            begin
                rp_reg[ch_idx]  <= ptr_inc(cur_rp);
                cnt_reg[ch_idx] <= cur_cnt - CNT_W'(1);
                rem_reg         <= rem_reg - RC_W'(1);
            end
        end
    end

    mcbf_ram #(
        .WIDTH(8),
        .DEPTH(MEM_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr({ch_idx, cur_wp}),
        .wdata(req_byte_reg),
        .re   (cmd.rd_issue),
        .raddr({ch_idx, cur_rp}),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit || cmd.rd_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg <= single_status;
            out_byte_reg   <= 8'd0;
            out_ch_reg     <= single_ch;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.rd_emit)
        begin
            out_status_reg <= ST_OK;
            out_byte_reg   <= ram_rdata;
            out_ch_reg     <= req_ch_reg;
            out_last_reg   <= (rem_reg == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign read_byte   = out_byte_reg;
    assign channel_out = out_ch_reg;
    assign last        = out_last_reg;

endmodule

// File: src/mcbf_ctrl.sv
module mcbf_ctrl
    import mcbf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RD_ISSUE,
        S_RD_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.read_go)
                begin
                    cmd.rd_start = 1'b1;
                    state_next   = S_RD_ISSUE;
                end
                else if (stat.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_EMIT;
            end
            S_RD_EMIT:
            begin
                // The byte stays in the RAM's read register until the output
                // register is free to take it.
                if (stat.slot_free)
                begin
                    cmd.rd_emit = 1'b1;
                    state_next  = stat.rd_more ? S_RD_ISSUE : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/multi_channel_byte_fifo_core.sv
// Channel   Direction  Handshake            Payload
// request   in         in_valid/in_ready    opcode, channel, write_byte, read_count
// result    out        out_valid/out_ready  status, read_byte, channel_out, last
//
// Allocate, free and write go through the load and execute states, one transfer result each.
// A read is decoded in the same states, then takes one RAM read and one emit per byte.
// A new request is taken while the last result still waits in the output register.
// After reset every channel is free and empty; the byte RAM needs no clearing.
module multi_channel_byte_fifo_core
    import mcbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [2:0] channel,
    input  logic [7:0] write_byte,
    input  logic [6:0] read_count,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] read_byte,
    output logic [2:0] channel_out,
    output logic       last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mcbf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mcbf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (opcode),
        .channel    (channel),
        .write_byte (write_byte),
        .read_count (read_count),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .status     (status),
        .read_byte  (read_byte),
        .channel_out(channel_out),
        .last       (last)
    );

endmodule

// File: sim/multi_channel_byte_fifo_core_tb.sv
module multi_channel_byte_fifo_core_tb;

    import mcbf_pkg::*;

    typedef struct packed {
        status_t    status;
        logic [7:0] data;
        logic [2:0] chan;
        logic       last;
    } fifo_result_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] chan;
        logic [7:0] data;
        logic [6:0] count;
        logic       typed;
        status_t    status;
        logic [2:0] chan_out;
    } request_row_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [1:0] opcode      = 2'd0;
    logic [2:0] channel     = 3'd0;
    logic [7:0] write_byte  = 8'd0;
    logic [6:0] read_count  = 7'd1;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [2:0] status;
    logic [7:0] read_byte;
    logic [2:0] channel_out;
    logic       last;

    // Shadow of the channel table, updated on every accepted request.
    logic       chan_free [NUM_CHANNELS];
    int         rd_ptr    [NUM_CHANNELS];
    int         wr_ptr    [NUM_CHANNELS];
    int         fill      [NUM_CHANNELS];
    logic [7:0] byte_mem  [NUM_CHANNELS][CHANNEL_DEPTH];

    fifo_result_t awaited_results [$];
    request_row_t directed_rows [$];

    fifo_result_t oldest;
    fifo_result_t row_result   = '0;
    logic         row_typed    = 1'b0;
    int           queued_before;
    int           mismatch_count = 0;
    int           stall_left     = 0;
    int           stall_pick;
    bit           idle_on        = 1'b1;

    multi_channel_byte_fifo_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .channel     (channel),
        .write_byte  (write_byte),
        .read_count  (read_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_byte   (read_byte),
        .channel_out (channel_out),
        .last        (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        $display("ERROR at %0t: %s is %0h, expected %0h", $time, field, got, want);
    endtask

    // Works out the results of one request and updates the shadow table.
    function automatic void apply_request(input op_t op, input logic [2:0] ch,
                                          input logic [7:0] wb, input logic [6:0] rc);
        int pick;
        int c;
        int n;
        fifo_result_t res;
        res.status = ST_OK;
        res.data   = 8'h00;
        res.chan   = ch;
        res.last   = 1'b1;
        c = int'(ch);
        if (op == OP_ALLOC)
        begin
            pick = -1;
            for (int i = NUM_CHANNELS - 1; i >= 0; i--)
            begin
                if (chan_free[i])
                begin
                    pick = i;
                end
            end
            if (pick < 0)
            begin
                res.status = ST_NOFREE;
                res.chan   = 3'd0;
            end
            else
            begin
                chan_free[pick] = 1'b0;
                rd_ptr[pick]    = 0;
                wr_ptr[pick]    = 0;
                fill[pick]      = 0;
                res.chan        = 3'(pick);
            end
            awaited_results.push_back(res);
        end
        else if (c >= NUM_CHANNELS || chan_free[c])
        begin
            res.status = ST_BADCH;
            awaited_results.push_back(res);
        end
        else if (op == OP_FREE)
        begin
            chan_free[c] = 1'b1;
            rd_ptr[c]    = 0;
            wr_ptr[c]    = 0;
            fill[c]      = 0;
            awaited_results.push_back(res);
        end
        else if (op == OP_WRITE)
        begin
            if (fill[c] >= CHANNEL_DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                byte_mem[c][wr_ptr[c]] = wb;
                wr_ptr[c] = (wr_ptr[c] + 1) % CHANNEL_DEPTH;
                fill[c]++;
            end
            awaited_results.push_back(res);
        end
        else if (fill[c] == 0)
        begin
            res.status = ST_EMPTY;
            awaited_results.push_back(res);
        end
        else
        begin
            // A count of zero still reads one byte; large counts are clipped.
            n = (rc == 7'd0) ? 1 : int'(rc);
            if (n > MAX_READ)
            begin
                n = MAX_READ;
            end
            if (n > fill[c])
            begin
                n = fill[c];
            end
            for (int k = 0; k < n; k++)
            begin
                res.data  = byte_mem[c][rd_ptr[c]];
                res.last  = (k == n - 1);
                rd_ptr[c] = (rd_ptr[c] + 1) % CHANNEL_DEPTH;
                fill[c]--;
                awaited_results.push_back(res);
            end
        end
    endfunction

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 15);
        if (!idle_on || roll < 10)
        begin
            return 0;
        end
        else if (roll < 15)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_pick = pick_gap();
            if (stall_pick == 0)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_pick - 1;
            end
        end
    end

    // Result transfers are checked before the request taken at the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("unawaited result, status", 8'(status), 8'h00);
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (status !== oldest.status)
                    begin
                        report_mismatch("status", 8'(status), 8'(oldest.status));
                    end
                    if (read_byte !== oldest.data)
                    begin
                        report_mismatch("read_byte", read_byte, oldest.data);
                    end
                    if (channel_out !== oldest.chan)
                    begin
                        report_mismatch("channel_out", 8'(channel_out), 8'(oldest.chan));
                    end
                    if (last !== oldest.last)
                    begin
                        report_mismatch("last", 8'(last), 8'(oldest.last));
                    end
                end
            end
            if (in_valid === 1'b1 && in_ready === 1'b1)
            begin
                queued_before = awaited_results.size();
                apply_request(op_t'(opcode), channel, write_byte, read_count);
                if (row_typed)
                begin
                    while (awaited_results.size() > queued_before)
                    begin
                        awaited_results.delete(awaited_results.size() - 1);
                    end
                    awaited_results.push_back(row_result);
                end
            end
        end
    end

    task automatic send_request(input op_t op, input logic [2:0] ch, input logic [7:0] wb,
                                input logic [6:0] rc, input logic typed,
                                input status_t st, input logic [2:0] cho);
        int gap;
        fifo_result_t res;
        res.status = st;
        res.data   = 8'h00;
        res.chan   = cho;
        res.last   = 1'b1;
        @(negedge clk);
        in_valid   <= 1'b1;
        opcode     <= op;
        channel    <= ch;
        write_byte <= wb;
        read_count <= rc;
        row_typed  <= typed;
        row_result <= res;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid   <= 1'b0;
            opcode     <= 2'($urandom_range(0, 3));
            channel    <= 3'($urandom_range(0, 7));
            write_byte <= 8'($urandom_range(0, 255));
            read_count <= 7'($urandom_range(0, 127));
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic add_row(input op_t op, input logic [2:0] ch, input logic [7:0] wb,
                           input logic [6:0] rc, input logic typed,
                           input status_t st, input logic [2:0] cho);
        request_row_t row;
        row.op       = op;
        row.chan     = ch;
        row.data     = wb;
        row.count    = rc;
        row.typed    = typed;
        row.status   = st;
        row.chan_out = cho;
        directed_rows.push_back(row);
    endtask

    // Well-formed traffic on allocated channels, with some requests aimed at free ones.
    task automatic send_random();
        int roll;
        int owned [$];
        op_t op;
        logic [2:0] ch;
        logic [6:0] rc;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (!chan_free[c])
            begin
                owned.push_back(c);
            end
        end
        roll = $urandom_range(0, 99);
        if (owned.size() == 0 || roll < 10)
        begin
            op = OP_ALLOC;
        end
        else if (roll < 18)
        begin
            op = OP_FREE;
        end
        else if (roll < 60)
        begin
            op = OP_WRITE;
        end
        else
        begin
            op = OP_READ;
        end
        if (owned.size() != 0 && $urandom_range(0, 9) != 0)
        begin
            ch = 3'(owned[$urandom_range(0, owned.size() - 1)]);
        end
        else
        begin
            ch = 3'($urandom_range(0, 7));
        end
        case ($urandom_range(0, 7))
            0:       rc = 7'd0;
            1:       rc = 7'd64;
            2:       rc = 7'($urandom_range(65, 127));
            3:       rc = 7'($urandom_range(1, 64));
            default: rc = 7'($urandom_range(1, 8));
        endcase
        send_request(op, ch, 8'($urandom_range(0, 255)), rc, 1'b0, ST_OK, 3'd0);
    endtask

    initial
    begin
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            chan_free[c] = 1'b1;
            rd_ptr[c]    = 0;
            wr_ptr[c]    = 0;
            fill[c]      = 0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Requests on free channels are refused until something is allocated.
        add_row(OP_READ,  3'd0, 8'h00, 7'd1,   1'b1, ST_BADCH,  3'd0);
        add_row(OP_WRITE, 3'd7, 8'hFF, 7'd1,   1'b1, ST_BADCH,  3'd7);
        add_row(OP_FREE,  3'd3, 8'h00, 7'd1,   1'b1, ST_BADCH,  3'd3);
        add_row(OP_ALLOC, 3'd7, 8'h00, 7'd1,   1'b1, ST_OK,     3'd0);
        add_row(OP_ALLOC, 3'd0, 8'h00, 7'd1,   1'b1, ST_OK,     3'd1);
        add_row(OP_READ,  3'd0, 8'h00, 7'd64,  1'b1, ST_EMPTY,  3'd0);
        add_row(OP_WRITE, 3'd0, 8'h00, 7'd1,   1'b1, ST_OK,     3'd0);
        add_row(OP_WRITE, 3'd0, 8'hFF, 7'd1,   1'b1, ST_OK,     3'd0);
        add_row(OP_WRITE, 3'd0, 8'hA5, 7'd1,   1'b1, ST_OK,     3'd0);
        add_row(OP_READ,  3'd0, 8'h00, 7'd0,   1'b0, ST_OK,     3'd0);
        add_row(OP_READ,  3'd0, 8'h00, 7'd127, 1'b0, ST_OK,     3'd0);
        add_row(OP_READ,  3'd0, 8'h00, 7'd1,   1'b1, ST_EMPTY,  3'd0);
        add_row(OP_WRITE, 3'd1, 8'h5A, 7'd1,   1'b1, ST_OK,     3'd1);
        add_row(OP_FREE,  3'd1, 8'h00, 7'd1,   1'b1, ST_OK,     3'd1);
        add_row(OP_READ,  3'd1, 8'h00, 7'd64,  1'b1, ST_BADCH,  3'd1);
        for (int c = 1; c < NUM_CHANNELS; c++)
        begin
            add_row(OP_ALLOC, 3'd0, 8'h00, 7'd1, 1'b1, ST_OK, 3'(c));
        end
        add_row(OP_ALLOC, 3'd5, 8'h00, 7'd1,   1'b1, ST_NOFREE, 3'd0);
        add_row(OP_FREE,  3'd7, 8'h00, 7'd1,   1'b1, ST_OK,     3'd7);
        add_row(OP_ALLOC, 3'd2, 8'h00, 7'd1,   1'b1, ST_OK,     3'd7);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].op, directed_rows[i].chan, directed_rows[i].data,
                         directed_rows[i].count, directed_rows[i].typed,
                         directed_rows[i].status, directed_rows[i].chan_out);
        end

        // Fill channel 0 past its depth so the pointers wrap and writes get dropped,
        // then drain it with full-length reads.
        for (int i = 0; i < CHANNEL_DEPTH + 2; i++)
        begin
            send_request(OP_WRITE, 3'd0, 8'($urandom_range(0, 255)), 7'd1, 1'b0, ST_OK, 3'd0);
        end
        repeat (5)
        begin
            send_request(OP_READ, 3'd0, 8'h00, 7'd64, 1'b0, ST_OK, 3'd0);
        end

        for (int blk = 0; blk < 10; blk++)
        begin
            idle_on = ($urandom_range(0, 2) != 0);
            repeat (10) send_random();
        end
        idle_on = 1'b1;

        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #200000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
